### rtl/core/i2cms_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
package i2cms_pkg;

  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_DONE    = 2'd1,
    FN_COLL    = 2'd2,
    FN_TIMEOUT = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_ADDRESS = 3'd1,
    PH_TX      = 3'd2,
    PH_RX      = 3'd3,
    PH_RESTART = 3'd4,
    PH_ACK     = 3'd5,
    PH_STOP    = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_START   = 4'd1,
    CMD_SEND    = 4'd2,
    CMD_RCEN    = 4'd3,
    CMD_ACK     = 4'd4,
    CMD_NACK    = 4'd5,
    CMD_RESTART = 4'd6,
    CMD_STOP    = 4'd7,
    CMD_RESET   = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUS     = 2'd1,
    ST_ACKFAIL = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  address;
    logic [15:0] tx_count;
    logic [15:0] rx_count;
    logic        ack_status;
    logic        collision;
    logic [7:0]  rx_data;
    logic [7:0]  tx_data;
  } item_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [7:0]  send_value;
    logic [15:0] tx_position;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic [15:0] rx_position;
    logic        done_res;
    logic [1:0]  status;
    logic        busy_res;
  } result_t;

endpackage

### rtl/core/i2cms_step.sv
// Transaction state registers and the sequencing logic for one item.
module i2cms_step import i2cms_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  output result_t res_o
);

  phase_e                phase_q, phase_d;
  logic [6:0]            addr_q, addr_d;
  logic [COUNT_BITS-1:0] tx_rem_q, tx_rem_d;
  logic [COUNT_BITS-1:0] rx_rem_q, rx_rem_d;
  logic [COUNT_BITS-1:0] tx_idx_q, tx_idx_d;
  logic [COUNT_BITS-1:0] rx_idx_q, rx_idx_d;
  logic                  active_q, active_d;
  logic [31:0]           tx_idx_ext;
  logic [31:0]           rx_idx_ext;
  cmd_e                  cmd;
  status_e               status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_STOP;
      addr_q   <= '0;
      tx_rem_q <= '0;
      rx_rem_q <= '0;
      tx_idx_q <= '0;
      rx_idx_q <= '0;
      active_q <= 1'b0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      tx_rem_q <= tx_rem_d;
      rx_rem_q <= rx_rem_d;
      tx_idx_q <= tx_idx_d;
      rx_idx_q <= rx_idx_d;
      active_q <= active_d;
    end
  end

  assign rx_idx_ext = 32'(rx_idx_q);

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    tx_rem_d = tx_rem_q;
    rx_rem_d = rx_rem_q;
    tx_idx_d = tx_idx_q;
    rx_idx_d = rx_idx_q;
    active_d = active_q;
    cmd      = CMD_NONE;
    status   = ST_OK;
    res_o    = '0;

    if (func_e'(item_i.func) == FN_START) begin
      if (!active_q) begin
        addr_d   = item_i.address;
        tx_rem_d = COUNT_BITS'(32'(item_i.tx_count));
        rx_rem_d = COUNT_BITS'(32'(item_i.rx_count));
        tx_idx_d = '0;
        rx_idx_d = '0;
        active_d = 1'b1;
        phase_d  = PH_START;
        cmd      = CMD_START;
      end
    end else if (active_q) begin
      if (func_e'(item_i.func) == FN_DONE && !item_i.collision) begin
        case (phase_q)
          PH_START: begin
            cmd     = CMD_SEND;
            phase_d = PH_ADDRESS;
            if (tx_rem_q != '0 || rx_rem_q == '0) begin
              res_o.send_value = {addr_q, 1'b0};
            end else begin
              res_o.send_value = {addr_q, 1'b1};
            end
          end
          PH_ADDRESS, PH_TX: begin
            if (item_i.ack_status) begin
              cmd      = CMD_RESET;
              status   = ST_ACKFAIL;
              res_o.done_res = 1'b1;
              active_d = 1'b0;
              phase_d  = PH_STOP;
            end else if (tx_rem_q != '0) begin
              cmd              = CMD_SEND;
              res_o.send_value = item_i.tx_data;
              tx_idx_d         = tx_idx_q + COUNT_BITS'(1);
              tx_rem_d         = tx_rem_q - COUNT_BITS'(1);
              phase_d          = PH_TX;
            end else if (rx_rem_q != '0) begin
              if (phase_q == PH_ADDRESS) begin
                cmd     = CMD_RCEN;
                phase_d = PH_RX;
              end else begin
                cmd     = CMD_RESTART;
                phase_d = PH_RESTART;
              end
            end else begin
              cmd     = CMD_STOP;
              phase_d = PH_STOP;
            end
          end
          PH_RX: begin
            res_o.rx_valid    = 1'b1;
            res_o.rx_byte     = item_i.rx_data;
            res_o.rx_position = rx_idx_ext[15:0];
            rx_idx_d          = rx_idx_q + COUNT_BITS'(1);
            if (rx_rem_q != '0) begin
              rx_rem_d = rx_rem_q - COUNT_BITS'(1);
            end
            cmd     = (rx_rem_d != '0) ? CMD_ACK : CMD_NACK;
            phase_d = PH_ACK;
          end
          PH_RESTART: begin
            cmd              = CMD_SEND;
            res_o.send_value = {addr_q, 1'b1};
            phase_d          = PH_ADDRESS;
          end
          PH_ACK: begin
            if (rx_rem_q != '0) begin
              cmd     = CMD_RCEN;
              phase_d = PH_RX;
            end else begin
              cmd     = CMD_STOP;
              phase_d = PH_STOP;
            end
          end
          default: begin
            cmd      = CMD_NONE;
            status   = ST_OK;
            res_o.done_res = 1'b1;
            active_d = 1'b0;
            phase_d  = PH_STOP;
          end
        endcase
      end else begin
        cmd = CMD_RESET;
        case (func_e'(item_i.func))
          FN_TIMEOUT: status = ST_TIMEOUT;
          default:    status = ST_BUS;
        endcase
        res_o.done_res = 1'b1;
        active_d = 1'b0;
        phase_d  = PH_STOP;
      end
    end

    tx_idx_ext        = 32'(tx_idx_d);
    res_o.command     = cmd;
    res_o.status      = status;
    res_o.tx_position = tx_idx_ext[15:0];
    res_o.busy_res    = active_d;
  end

endmodule

### rtl/core/i2c_master_transaction_sequencer_core.sv
// Top level of the I2C master transaction sequencer: input stage and result register.
//
//   Channel  Direction  Handshake                   Payload
//   in       sink       in_valid_i / in_stall_o     func_i .. tx_data_i
//   out      source     out_valid_o / out_stall_i   command_o .. busy_res_o
//
// One item is accepted per cycle while the input stage is not stalled. The input
// register feeds the sequencing logic, which updates the transaction state and
// loads the result register in the same edge.
// Reset clears the transaction state and both valid flags.
// A stall on the result side holds the result register and then the input stage.
module i2c_master_transaction_sequencer_core import i2cms_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [6:0]  address_i,
  input  logic [15:0] tx_count_i,
  input  logic [15:0] rx_count_i,
  input  logic        ack_status_i,
  input  logic        collision_i,
  input  logic [7:0]  rx_data_i,
  input  logic [7:0]  tx_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  command_o,
  output logic [7:0]  send_value_o,
  output logic [15:0] tx_position_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_byte_o,
  output logic [15:0] rx_position_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic        busy_res_o
);

  logic    in_vld_q;
  item_t   in_item_q;
  logic    out_vld_q;
  result_t res_q;
  result_t res;
  logic    advance;
  logic    in_take;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= '{func: func_i, address: address_i, tx_count: tx_count_i,
                     rx_count: rx_count_i, ack_status: ack_status_i,
                     collision: collision_i, rx_data: rx_data_i, tx_data: tx_data_i};
    end
    if (advance) begin
      res_q <= res;
    end
  end

  i2cms_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  assign out_valid_o   = out_vld_q;
  assign command_o     = res_q.command;
  assign send_value_o  = res_q.send_value;
  assign tx_position_o = res_q.tx_position;
  assign rx_valid_o    = res_q.rx_valid;
  assign rx_byte_o     = res_q.rx_byte;
  assign rx_position_o = res_q.rx_position;
  assign done_res_o    = res_q.done_res;
  assign status_o      = res_q.status;
  assign busy_res_o    = res_q.busy_res;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("finished transaction still reports busy");

  a_error_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> done_res_o && command_o == CMD_RESET)
    else $error("error status without module reset");

  a_rx_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |-> command_o == CMD_ACK || command_o == CMD_NACK)
    else $error("received byte not answered with ACK or NACK");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_item_q))
    else $error("input stage lost a held item");

endmodule
